FILE: rtl/monitor_id_allocator_assert.svh
// assertion macros for the monitor id allocator
// used by the top level only, empty when SYNTHESIS is defined
`ifndef MONITOR_ID_ALLOCATOR_ASSERT_SVH
`define MONITOR_ID_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define MIA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("monitor_id_allocator assertion failed");
// cause in one cycle implies effect in the next
`define MIA_ASSERT_NEXT(label, cause, effect) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("monitor_id_allocator assertion failed");
`else
`define MIA_ASSERT(label, prop)
`define MIA_ASSERT_NEXT(label, cause, effect)
`endif
`endif

FILE: rtl/mia_pkg.sv
// shared types and constants of the monitor id allocator
// no dependencies; imported by mia_ctrl, mia_dpath and the top level
`default_nettype none
package mia_pkg;
   localparam int KIND_W     = 2;
   localparam int ID_NUM_W   = 6;
   localparam int TOTAL_W    = 7;
   localparam int MON_W      = 5;
   localparam int MEM_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam int NUM_RESOURCES_DEF = 2;
   localparam int MAX_IDS_DEF       = 64;
   localparam int MAX_MONITORS_DEF  = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_INIT, KIND_ASSOC, KIND_DEASSOC, KIND_QUERY
   } kind_type;

   typedef enum logic [MEM_W-1:0] {
      MEM_NONE, MEM_DONE, MEM_WAIT
   } member_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIDE, CSR_ENABLE, CSR_MON_RES0, CSR_MON_RES1
   } csr_index_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ID_NUM_W-1:0] id_number;
      logic                resource_index;
      logic [TOTAL_W-1:0]  id_total;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [MON_W-1:0] monitor;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_LOOKUP, ST_TAKE, ST_ASSOC_END,
      ST_WALK_RD, ST_WALK_ID, ST_WALK_ROW, ST_FREE, ST_RESP
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic do_init;
      logic rd_row_req;
      logic load_lookup;
      logic take_step;
      logic assoc_finish;
      logic rd_wait;
      logic rd_wait_row;
      logic skip_waiter;
      logic serve_waiter;
      logic deassoc_finish;
      logic set_error;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     id_ok;
      logic     member_none;
      logic     take_last;
      logic     walk_done;
      logic     waiter_is_self;
      logic     rsp_free;
   } stat_type;
endpackage
`default_nettype wire

FILE: rtl/mia_ram.sv
// generic one-write one-read ram with registered read data
// no dependencies
`default_nettype none
module mia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/mia_ctrl.sv
// sequencer of the monitor id allocator
// depends on mia_pkg; drives the datapath through cmd_type
`default_nettype none
module mia_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mia_pkg::stat_type stat,
   output mia_pkg::cmd_type       cmd
);
   import mia_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.kind == KIND_INIT) begin
               cmd.do_init = 1'b1;
               state_in    = ST_RESP;
            end else if (!stat.id_ok) begin
               cmd.set_error = 1'b1;
               state_in      = ST_RESP;
            end else begin
               cmd.rd_row_req = 1'b1;
               state_in       = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.load_lookup = 1'b1;
            if (stat.kind == KIND_QUERY) begin
               state_in = ST_RESP;
            end else if (stat.kind == KIND_ASSOC) begin
               if (stat.member_none) begin
                  state_in = ST_TAKE;
               end else begin
                  cmd.set_error = 1'b1;
                  state_in      = ST_RESP;
               end
            end else begin
               if (stat.member_none) begin
                  cmd.set_error = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_TAKE: begin
            cmd.take_step = 1'b1;
            if (stat.take_last) begin
               state_in = ST_ASSOC_END;
            end
         end
         ST_ASSOC_END: begin
            cmd.assoc_finish = 1'b1;
            state_in         = ST_RESP;
         end
         ST_WALK_RD: begin
            if (stat.walk_done) begin
               state_in = ST_FREE;
            end else begin
               cmd.rd_wait = 1'b1;
               state_in    = ST_WALK_ID;
            end
         end
         ST_WALK_ID: begin
            if (stat.waiter_is_self) begin
               cmd.skip_waiter = 1'b1;
               state_in        = ST_WALK_RD;
            end else begin
               cmd.rd_wait_row = 1'b1;
               state_in        = ST_WALK_ROW;
            end
         end
         ST_WALK_ROW: begin
            cmd.serve_waiter = 1'b1;
            state_in         = ST_WALK_RD;
         end
         ST_FREE: begin
            cmd.deassoc_finish = 1'b1;
            state_in           = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/mia_dpath.sv
// datapath of the monitor id allocator: config, free maps, id rows, wait list
// depends on mia_pkg and mia_ram; commanded by mia_ctrl
`default_nettype none
module mia_dpath #(
   parameter int NUM_RES = mia_pkg::NUM_RESOURCES_DEF,
   parameter int MAX_IDS = mia_pkg::MAX_IDS_DEF,
   parameter int MAX_MON = mia_pkg::MAX_MONITORS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire mia_pkg::req_type                 req_data,
   output mia_pkg::rsp_type                      rsp_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic                             csr_valid,
   input  wire logic [mia_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mia_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire mia_pkg::cmd_type                 cmd,
   output mia_pkg::stat_type                     stat
);
   import mia_pkg::*;

   localparam int ID_W  = $clog2(MAX_IDS);
   localparam int CNT_W = $clog2(MAX_IDS + 1);
   localparam int RES_W = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
   localparam int ROW_W = MEM_W + NUM_RES * MON_W;
   localparam int EXT_W = CNT_W + TOTAL_W;

   // mask of the monitor group starting at mon, two monitors wide when two is set
   function automatic logic [MAX_MON-1:0] group_bits(input logic [MON_W-1:0] mon,
                                                     input logic two);
      logic [MAX_MON-1:0] g;
      g = '0;
      for (int b = 0; b < MAX_MON; b++) begin
         g[b] = (b == int'(mon)) || (two && (b == int'(mon) + 1));
      end
      return g;
   endfunction

   function automatic logic res_en(input int r, input logic [1:0] mask);
      return (r == 0 && mask[0]) || (r == 1 && mask[1]);
   endfunction

   // registers
   req_type              req_ff, req_in;
   logic [1:0]           stride_ff, stride_in;
   logic [1:0]           enable_ff, enable_in;
   logic [5:0]           mon0_ff, mon0_in;
   logic [5:0]           mon1_ff, mon1_in;
   logic [MAX_MON-1:0]   map_ff [NUM_RES];
   logic [MAX_MON-1:0]   map_in [NUM_RES];
   logic [MAX_IDS-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [CNT_W-1:0]     wlen_ff, wlen_in;
   logic [CNT_W-1:0]     walk_ff, walk_in;
   logic [CNT_W-1:0]     kept_ff, kept_in;
   logic [RES_W-1:0]     rcnt_ff, rcnt_in;
   logic [ROW_W-1:0]     cur_ff, cur_in;
   logic                 short_ff, short_in;
   logic [ID_W-1:0]      waiter_ff, waiter_in;
   logic [ID_W-1:0]      raddr_ff;
   logic                 st_ff, st_in;
   logic [MON_W-1:0]     mon_ff, mon_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rvalid_ff, rvalid_in;

   // ram ports
   logic                 row_we;
   logic [ID_W-1:0]      row_wa, row_ra;
   logic [ROW_W-1:0]     row_wd, row_rq, row_rd;
   logic                 wait_we;
   logic [ID_W-1:0]      wait_wa, wait_ra, wait_wd, wait_rq;

   // scratch
   logic [EXT_W-1:0]     id_ext, lim_ext, tot_ext;
   logic [ID_W-1:0]      req_idx;
   logic                 two;
   logic [MAX_MON-1:0]   map_sel;
   logic                 found;
   logic [MON_W-1:0]     low;
   logic [ROW_W-1:0]     w_row, e_row;
   logic                 w_short;
   logic [MON_W-1:0]     wm, q_mon;
   logic [6:0]           cnt;
   logic [1:0]           base;

   mia_ram #(.WIDTH(ROW_W), .DEPTH(MAX_IDS)) u_row_ram (
      .clock(clock), .wr_en(row_we), .wr_addr(row_wa), .wr_data(row_wd),
      .rd_addr(row_ra), .rd_data(row_rq)
   );

   mia_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_wait_ram (
      .clock(clock), .wr_en(wait_we), .wr_addr(wait_wa), .wr_data(wait_wd),
      .rd_addr(wait_ra), .rd_data(wait_rq)
   );

   assign id_ext  = EXT_W'(req_ff.id_number);
   assign lim_ext = EXT_W'(limit_ff);
   assign tot_ext = EXT_W'(req_ff.id_total);
   assign req_idx = id_ext[ID_W-1:0];
   assign two     = stride_ff[1];
   // rows never written since init read as all none
   assign row_rd  = valid_ff[raddr_ff] ? row_rq : '0;

   // status to the sequencer
   always_comb begin
      stat.kind           = kind_type'(req_ff.kind);
      stat.id_ok          = id_ext < lim_ext;
      stat.member_none    = row_rd[MEM_W-1:0] == MEM_NONE;
      stat.take_last      = int'(rcnt_ff) == NUM_RES - 1;
      stat.walk_done      = walk_ff >= wlen_ff;
      stat.waiter_is_self = wait_rq == req_idx;
      stat.rsp_free       = !rvalid_ff || rsp_ready;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rvalid_ff;

   // next values of all datapath registers
   always_comb begin
      req_in    = req_ff;
      stride_in = stride_ff;
      enable_in = enable_ff;
      mon0_in   = mon0_ff;
      mon1_in   = mon1_ff;
      map_in    = map_ff;
      valid_in  = valid_ff;
      limit_in  = limit_ff;
      wlen_in   = wlen_ff;
      walk_in   = walk_ff;
      kept_in   = kept_ff;
      rcnt_in   = rcnt_ff;
      cur_in    = cur_ff;
      short_in  = short_ff;
      waiter_in = waiter_ff;
      st_in     = st_ff;
      mon_in    = mon_ff;
      rsp_in    = rsp_ff;
      rvalid_in = rvalid_ff;
      row_we    = 1'b0;
      row_wa    = req_idx;
      row_wd    = cur_ff;
      row_ra    = cmd.rd_wait_row ? wait_rq : req_idx;
      wait_we   = 1'b0;
      wait_wa   = kept_ff[ID_W-1:0];
      wait_wd   = waiter_ff;
      wait_ra   = walk_ff[ID_W-1:0];
      map_sel   = map_ff[rcnt_ff];
      found     = 1'b0;
      low       = '0;
      w_row     = row_rd;
      e_row     = cur_ff;
      w_short   = 1'b0;
      wm        = '0;
      q_mon     = '0;
      cnt       = '0;
      base      = '0;

      // configuration writes
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_STRIDE:   stride_in = csr_data[1:0];
            CSR_ENABLE:   enable_in = csr_data[1:0];
            CSR_MON_RES0: mon0_in   = csr_data;
            CSR_MON_RES1: mon1_in   = csr_data;
            default:      stride_in = stride_ff;
         endcase
      end

      // lowest free monitor of the current resource
      for (int b = MAX_MON - 1; b >= 0; b--) begin
         if (map_sel[b]) begin
            found = 1'b1;
            low   = MON_W'(b);
         end
      end

      if (cmd.latch_req) begin
         req_in = req_data;
         st_in  = 1'b0;
         mon_in = '0;
      end

      // init: clear rows and wait list; unless the total is zero, rebuild free maps
      if (cmd.do_init) begin
         valid_in = '0;
         wlen_in  = '0;
         limit_in = (tot_ext > EXT_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : CNT_W'(tot_ext);
         if (tot_ext == '0) begin
            st_in = 1'b1;
         end else begin
            row_we = 1'b1;
            row_wa = '0;
            row_wd = ROW_W'(MEM_DONE);
            base   = two ? 2'd2 : 2'd1;
            for (int r = 0; r < NUM_RES; r++) begin
               cnt = (r == 0) ? 7'(mon0_ff) : (r == 1) ? 7'(mon1_ff) : 7'd0;
               if (int'(cnt) > MAX_MON) begin
                  cnt = 7'(MAX_MON);
               end
               if (two) begin
                  cnt[0] = 1'b0;
               end
               for (int b = 0; b < MAX_MON; b++) begin
                  map_in[r][b] = (b < int'(cnt)) && (b >= int'(base));
               end
            end
         end
      end

      // capture the addressed row; answer a query
      if (cmd.load_lookup) begin
         cur_in   = row_rd;
         rcnt_in  = '0;
         walk_in  = '0;
         kept_in  = '0;
         short_in = 1'b0;
         for (int r = 0; r < NUM_RES; r++) begin
            if (r == int'(req_ff.resource_index)) begin
               q_mon = row_rd[MEM_W + r*MON_W +: MON_W];
            end
         end
         if (kind_type'(req_ff.kind) == KIND_QUERY) begin
            if (row_rd[MEM_W-1:0] == MEM_NONE || int'(req_ff.resource_index) >= NUM_RES) begin
               st_in = 1'b1;
            end else begin
               mon_in = q_mon;
            end
         end
      end

      // associate: one resource a cycle
      if (cmd.take_step) begin
         rcnt_in = rcnt_ff + RES_W'(1);
         if (res_en(int'(rcnt_ff), enable_ff)) begin
            if (found) begin
               map_in[rcnt_ff] = map_sel & ~group_bits(low, two);
            end
            cur_in[MEM_W + int'(rcnt_ff)*MON_W +: MON_W] = found ? low : '0;
            if (!found || low == '0) begin
               short_in = 1'b1;
            end
         end
      end

      if (cmd.assoc_finish) begin
         row_we = 1'b1;
         if (short_ff && int'(wlen_ff) < MAX_IDS) begin
            wait_we              = 1'b1;
            wait_wa              = wlen_ff[ID_W-1:0];
            wait_wd              = req_idx;
            wlen_in              = wlen_ff + CNT_W'(1);
            row_wd[MEM_W-1:0]    = MEM_WAIT;
         end else begin
            row_wd[MEM_W-1:0]    = MEM_DONE;
         end
      end

      // deassociate walk over the wait list
      if (cmd.rd_wait_row) begin
         waiter_in = wait_rq;
      end
      if (cmd.skip_waiter) begin
         walk_in = walk_ff + CNT_W'(1);
      end
      if (cmd.serve_waiter) begin
         for (int r = 0; r < NUM_RES; r++) begin
            if (res_en(r, enable_ff)) begin
               wm = w_row[MEM_W + r*MON_W +: MON_W];
               if (wm == '0) begin
                  wm = e_row[MEM_W + r*MON_W +: MON_W];
                  e_row[MEM_W + r*MON_W +: MON_W] = '0;
               end
               w_row[MEM_W + r*MON_W +: MON_W] = wm;
               if (wm == '0) begin
                  w_short = 1'b1;
               end
            end
         end
         if (!w_short) begin
            w_row[MEM_W-1:0] = MEM_DONE;
         end
         row_we  = 1'b1;
         row_wa  = waiter_ff;
         row_wd  = w_row;
         cur_in  = e_row;
         walk_in = walk_ff + CNT_W'(1);
         if (w_short) begin
            wait_we = 1'b1;
            kept_in = kept_ff + CNT_W'(1);
         end
      end

      // free what the leaving id still holds
      if (cmd.deassoc_finish) begin
         for (int r = 0; r < NUM_RES; r++) begin
            if (res_en(r, enable_ff) && cur_ff[MEM_W + r*MON_W +: MON_W] != '0) begin
               map_in[r] = map_ff[r] | group_bits(cur_ff[MEM_W + r*MON_W +: MON_W], two);
            end
         end
         row_we            = 1'b1;
         row_wd[MEM_W-1:0] = MEM_NONE;
         wlen_in           = kept_ff;
      end

      if (cmd.set_error) begin
         st_in = 1'b1;
      end

      if (row_we) begin
         valid_in[row_wa] = 1'b1;
      end

      // result register
      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_in.status  = st_ff;
         rsp_in.monitor = mon_ff;
         rvalid_in      = 1'b1;
      end
   end

   // control and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= 2'd1;
         enable_ff <= '0;
         mon0_ff   <= '0;
         mon1_ff   <= '0;
         for (int r = 0; r < NUM_RES; r++) begin
            map_ff[r] <= '0;
         end
         valid_ff  <= '0;
         limit_ff  <= '0;
         wlen_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         stride_ff <= stride_in;
         enable_ff <= enable_in;
         mon0_ff   <= mon0_in;
         mon1_ff   <= mon1_in;
         map_ff    <= map_in;
         valid_ff  <= valid_in;
         limit_ff  <= limit_in;
         wlen_ff   <= wlen_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      walk_ff   <= walk_in;
      kept_ff   <= kept_in;
      rcnt_ff   <= rcnt_in;
      cur_ff    <= cur_in;
      short_ff  <= short_in;
      waiter_ff <= waiter_in;
      raddr_ff  <= row_ra;
      st_ff     <= st_in;
      mon_ff    <= mon_in;
      rsp_ff    <= rsp_in;
   end
endmodule
`default_nettype wire

FILE: rtl/monitor_id_allocator.sv
// top level of the monitor id allocator: sequencer plus datapath
// depends on mia_pkg, mia_ctrl, mia_dpath and monitor_id_allocator_assert.svh
//
// One request beat on req_* (init, associate, deassociate, query) gives one
// response beat on rsp_* with a status bit and a monitor number. Requests are
// handled one at a time; req_ready is high only while the sequencer is idle.
// Init and a rejected id pass from the check state to the response state; a query
// adds the row lookup, associate the take steps over the resources and the row
// write, deassociate a walk over the wait list through the id row ram.
// The response sits in an output register; the next request is taken while
// it waits, and only the following response stalls until rsp_ready.
// csr_* writes the stride, enable mask and per-resource monitor counts; it is
// always ready and is meant to be written only while the block is idle.
// Reset (synchronous) empties all tables, sets the stride to one and leaves
// the free maps empty until an init request.
`default_nettype none
`include "monitor_id_allocator_assert.svh"
module monitor_id_allocator #(
   parameter int NUM_RESOURCES = mia_pkg::NUM_RESOURCES_DEF,
   parameter int MAX_IDS       = mia_pkg::MAX_IDS_DEF,
   parameter int MAX_MONITORS  = mia_pkg::MAX_MONITORS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire mia_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output mia_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mia_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mia_pkg::CSR_DATA_W-1:0] csr_data
);
   import mia_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   mia_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .stat(stat), .cmd(cmd)
   );

   mia_dpath #(
      .NUM_RES(NUM_RESOURCES), .MAX_IDS(MAX_IDS), .MAX_MON(MAX_MONITORS)
   ) u_dpath (
      .clock(clock), .reset(reset), .req_data(req_data), .rsp_data(rsp_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .csr_valid(csr_valid & csr_ready),
      .csr_index(csr_index), .csr_data(csr_data), .cmd(cmd), .stat(stat)
   );

   // table writers never overlap, results never overwrite, one item at a time
   `MIA_ASSERT(a_one_writer, $onehot0({cmd.do_init, cmd.assoc_finish, cmd.serve_waiter, cmd.deassoc_finish}))
   `MIA_ASSERT(a_no_overwrite, cmd.load_rsp |-> (!rsp_valid || rsp_ready))
   `MIA_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// testbench for monitor_id_allocator: directed and random request beats,
// checked against an in-bench model of the allocator; depends on mia_pkg
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import mia_pkg::*;

   localparam int IDS      = 64;
   localparam int DRAIN    = 250;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int errors = 0;
   bit quiet = 1'b0;
   bit rsp_hold = 1'b0;
   rsp_type expected_rsps[$];

   // allocator model state
   bit [1:0] cfg_stride, cfg_enable;
   bit [5:0] cfg_mon0, cfg_mon1;
   bit [31:0] free_map[2];
   member_type membership[IDS];
   bit [4:0] id_mon[IDS*2];
   bit [5:0] waiters[IDS];
   int waiter_count;
   int id_limit;

   monitor_id_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int eff_stride();
      if (cfg_stride == 2'd0) return 1;
      if (cfg_stride == 2'd3) return 2;
      return int'(cfg_stride);
   endfunction

   function automatic bit res_on(int r);
      return cfg_enable[r];
   endfunction

   function automatic bit [31:0] group_of(int mon);
      bit [63:0] g;
      g = ((64'd1 << eff_stride()) - 64'd1) << (mon & 31);
      return g[31:0];
   endfunction

   function automatic bit [4:0] take_mon(int r);
      for (int b = 0; b < 32; b++) begin
         if (free_map[r][b]) begin
            free_map[r] = free_map[r] & ~group_of(b);
            return b[4:0];
         end
      end
      return 5'd0;
   endfunction

   function automatic void build_maps();
      int s, n;
      bit [63:0] m;
      s = eff_stride();
      for (int r = 0; r < 2; r++) begin
         n = (r == 0) ? int'(cfg_mon0) : int'(cfg_mon1);
         if (n > 32) n = 32;
         n -= n % s;
         m = (64'd1 << n) - 64'd1;
         m &= ~((64'd1 << s) - 64'd1);
         free_map[r] = m[31:0];
      end
   endfunction

   function automatic void model_reset();
      cfg_stride = 2'd1;
      cfg_enable = '0;
      cfg_mon0 = '0;
      cfg_mon1 = '0;
      free_map[0] = '0;
      free_map[1] = '0;
      foreach (membership[i]) membership[i] = MEM_NONE;
      foreach (id_mon[i]) id_mon[i] = '0;
      waiter_count = 0;
      id_limit = 0;
   endfunction

   // one response per request beat
   function automatic rsp_type allocate_step(req_type rq);
      rsp_type rs;
      int id, total, kept, w;
      bit short_of;
      rs = '{status: 1'b1, monitor: 5'd0};
      id = int'(rq.id_number);
      case (kind_type'(rq.kind))
         KIND_INIT: begin
            total = int'(rq.id_total);
            if (total > IDS) total = IDS;
            foreach (membership[i]) membership[i] = MEM_NONE;
            foreach (id_mon[i]) id_mon[i] = '0;
            waiter_count = 0;
            id_limit = total;
            if (total != 0) begin
               membership[0] = MEM_DONE;
               build_maps();
               rs.status = 1'b0;
            end
         end
         KIND_ASSOC: begin
            if (id < id_limit && membership[id] == MEM_NONE) begin
               short_of = 1'b0;
               for (int r = 0; r < 2; r++) begin
                  if (res_on(r)) begin
                     id_mon[id*2+r] = take_mon(r);
                     if (id_mon[id*2+r] == 0) short_of = 1'b1;
                  end
               end
               if (short_of && waiter_count < IDS) begin
                  waiters[waiter_count] = id[5:0];
                  waiter_count++;
                  membership[id] = MEM_WAIT;
               end else begin
                  membership[id] = MEM_DONE;
               end
               rs.status = 1'b0;
            end
         end
         KIND_DEASSOC: begin
            if (id < id_limit && membership[id] != MEM_NONE) begin
               membership[id] = MEM_NONE;
               kept = 0;
               // hand the leaving monitors down the wait list in order
               for (int i = 0; i < waiter_count; i++) begin
                  w = int'(waiters[i]);
                  if (w != id) begin
                     short_of = 1'b0;
                     for (int r = 0; r < 2; r++) begin
                        if (res_on(r)) begin
                           if (id_mon[w*2+r] == 0) begin
                              id_mon[w*2+r] = id_mon[id*2+r];
                              id_mon[id*2+r] = '0;
                           end
                           if (id_mon[w*2+r] == 0) short_of = 1'b1;
                        end
                     end
                     if (short_of) begin
                        waiters[kept] = w[5:0];
                        kept++;
                     end else begin
                        membership[w] = MEM_DONE;
                     end
                  end
               end
               waiter_count = kept;
               for (int r = 0; r < 2; r++)
                  if (res_on(r) && id_mon[id*2+r] != 0)
                     free_map[r] = free_map[r] | group_of(id_mon[id*2+r]);
               rs.status = 1'b0;
            end
         end
         default: begin
            if (id < id_limit && membership[id] != MEM_NONE) begin
               rs.monitor = id_mon[id*2+int'(rq.resource_index)];
               rs.status = 1'b0;
            end
         end
      endcase
      return rs;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
   endtask

   // receiver side: random stalls, a hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !rsp_hold && (quiet || $urandom_range(99) >= 13);
   end

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("outstanding beats", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.monitor !== want.monitor)
               report_mismatch("monitor", rsp_data.monitor, want.monitor);
         end
      end
   end

   // send one request beat; valid stays up across back-to-back beats
   task automatic send_req(req_type rq);
      if (!quiet && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(allocate_step(rq));
   endtask

   task automatic send(kind_type k, int id, int res = 0, int total = 0);
      req_type rq;
      rq.kind = k;
      rq.id_number = id[5:0];
      rq.resource_index = res[0];
      rq.id_total = total[6:0];
      send_req(rq);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[5:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_STRIDE:   cfg_stride = value[1:0];
         CSR_ENABLE:   cfg_enable = value[1:0];
         CSR_MON_RES0: cfg_mon0 = value[5:0];
         default:      cfg_mon1 = value[5:0];
      endcase
   endtask

   task automatic set_config(int s, int en, int n0, int n1);
      wait_idle();
      write_csr(CSR_STRIDE, s);
      write_csr(CSR_ENABLE, en);
      write_csr(CSR_MON_RES0, n0);
      write_csr(CSR_MON_RES1, n1);
      @(posedge clock);
   endtask

   // associate, deassociate and query before any init are rejected
   task automatic test_before_init();
      send(KIND_ASSOC, 0);
      send(KIND_DEASSOC, 63);
      send(KIND_QUERY, 0, 1);
   endtask

   // exhaust a small pool, build a wait list, then unwind it
   task automatic test_directed();
      set_config(1, 3, 5, 32);
      send(KIND_INIT, 0, 0, 127);
      for (int i = 1; i <= 6; i++) send(KIND_ASSOC, i);
      send(KIND_ASSOC, 3);
      send(KIND_QUERY, 5, 0);
      send(KIND_QUERY, 5, 1);
      send(KIND_QUERY, 0, 1);
      send(KIND_DEASSOC, 1);
      send(KIND_DEASSOC, 1);
      send(KIND_QUERY, 5, 0);
      send(KIND_DEASSOC, 6);
      send(KIND_QUERY, 63, 1);
      send(KIND_INIT, 0, 0, 0);
      send(KIND_QUERY, 0, 0);
      send(KIND_INIT, 0, 0, 2);
      send(KIND_ASSOC, 2);
      send(KIND_ASSOC, 1);
      send(KIND_QUERY, 1, 0);
   endtask

   task automatic random_items(int count);
      int pick, id;
      for (int n = 0; n < count; n++) begin
         quiet = (n >= count / 2 && n < count / 2 + 40);
         pick = $urandom_range(99);
         if (id_limit > 0 && $urandom_range(99) < 88) id = $urandom_range(id_limit - 1);
         else id = $urandom_range(63);
         if (pick < 3)
            send(KIND_INIT, id, 0, ($urandom_range(9) == 0) ? $urandom_range(127)
                                                                : $urandom_range(24, 1));
         else if (pick < 45) send(KIND_ASSOC, id);
         else if (pick < 75) send(KIND_DEASSOC, id);
         else send(KIND_QUERY, id, $urandom_range(1));
      end
      quiet = 1'b0;
   endtask

   // several settings, extremes among them
   task automatic test_random();
      int settings[8][4] = '{
         '{1, 3, 6, 9}, '{2, 3, 8, 5}, '{0, 1, 63, 0}, '{3, 2, 0, 63},
         '{1, 0, 32, 32}, '{2, 3, 32, 32}, '{1, 3, 2, 3}, '{3, 3, 11, 4}};
      for (int p = 0; p < 8; p++) begin
         set_config(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
         send(KIND_INIT, 0, 0, $urandom_range(40, 8));
         random_items(172);
      end
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      set_config(1, 3, 4, 4);
      send(KIND_INIT, 0, 0, 16);
      fork
         begin
            @(posedge clock);
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            for (int i = 1; i < 16; i++) send(KIND_ASSOC, i);
            for (int i = 1; i < 6; i++) send(KIND_DEASSOC, i);
         end
      join
   endtask

   initial begin
      model_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_init();
      test_directed();
      test_random();
      test_backpressure();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
